[hdl/bgad_pkg.sv]
// Shared types and constants of the gray block-average downscaler.
package bgad_pkg;

  localparam int CFG_W    = 11;  // width of every configuration register
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 28;  // column sum
  localparam int BS_W     = 21;  // block size in pixels
  localparam int NUM_W    = SUM_W + 1;  // sum plus half a block
  localparam int QUO_W    = PIX_W + 1;  // quotient bits, top bit flags saturation
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W   = 4;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int MAX_SRC_WIDTH  = 1024;
  localparam int MAX_SRC_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 11'd480;
  localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 11'd64;
  localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 11'd48;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  // Derived geometry handed from the configuration unit to the datapath.
  typedef struct packed {
    logic             busy;
    logic             ok;
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [CFG_W-1:0] bx;
    logic [CFG_W-1:0] by;
    logic [BS_W-1:0]  bsize;
  } cfg_stat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic acc;
    logic div;
    logic load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
  } dp_stat_t;

endpackage

[hdl/bgad_if.sv]
// Stream interfaces for source pixels and averaged result pixels.
interface bgad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface bgad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] avg_pixel;
  logic       frame_end;

  modport source (output valid, output avg_pixel, output frame_end, input ready);
  modport sink (input valid, input avg_pixel, input frame_end, output ready);
endinterface

[hdl/bgad_cfg.sv]
// Configuration registers and the iterative unit that derives block geometry.
module bgad_cfg #(
  parameter int MAX_DST_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bgad_pkg::APB_AW-1:0]    paddr,
  input  logic [bgad_pkg::APB_DW-1:0]    pwdata,
  output logic [bgad_pkg::APB_DW-1:0]    prdata,
  output bgad_pkg::cfg_stat_t            stat
);
  import bgad_pkg::*;

  typedef enum logic [2:0] {C_LOAD, C_DIV_W, C_DIV_H, C_MUL, C_DONE} cstate_t;

  localparam logic [12:0] MAX_SW = 13'(MAX_SRC_WIDTH);
  localparam logic [12:0] MAX_SH = 13'(MAX_SRC_HEIGHT);
  localparam logic [12:0] MAX_DW = 13'(MAX_DST_WIDTH);

  cstate_t          state_r;
  logic             busy_r, ok_r, rw_zero_r, rh_zero_r;
  logic [CFG_W-1:0] sw_r, sh_r, dw_r, dh_r;
  logic [CFG_W-1:0] rem_r, quo_r, bx_r, by_r;
  logic [STEP_W-1:0] step_r;
  logic [BS_W-1:0]  bsize_r;

  logic             wr;
  reg_idx_t         idx;
  logic [CFG_W-1:0] divisor;
  logic [CFG_W:0]   trial;
  logic             ge;
  logic [CFG_W-1:0] rem_nxt, quo_nxt;
  logic             last_step;
  logic             ok_nxt;
  logic [2*CFG_W-1:0] prod;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[3:2]);

  // One restoring-division step: shift in a dividend bit, subtract if it fits.
  assign divisor   = (state_r == C_DIV_H) ? dh_r : dw_r;
  assign trial     = {rem_r, quo_r[CFG_W-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign rem_nxt   = ge ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
  assign quo_nxt   = {quo_r[CFG_W-2:0], ge};
  assign last_step = step_r == STEP_W'(CFG_W - 1);
  assign prod      = bx_r * by_r;

  assign ok_nxt = (sw_r != '0) && ({2'b0, sw_r} <= MAX_SW) &&
                  (sh_r != '0) && ({2'b0, sh_r} <= MAX_SH) &&
                  (dw_r != '0) && ({2'b0, dw_r} <= MAX_DW) &&
                  (dh_r != '0) && rw_zero_r && rh_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_LOAD;
      busy_r  <= 1'b1;
      ok_r    <= 1'b0;
      sw_r    <= RST_SRC_WIDTH;
      sh_r    <= RST_SRC_HEIGHT;
      dw_r    <= RST_DST_WIDTH;
      dh_r    <= RST_DST_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_SRC_WIDTH:  sw_r <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: sh_r <= pwdata[CFG_W-1:0];
        REG_DST_WIDTH:  dw_r <= pwdata[CFG_W-1:0];
        REG_DST_HEIGHT: dh_r <= pwdata[CFG_W-1:0];
      endcase
      state_r <= C_LOAD;
      busy_r  <= 1'b1;
    end else begin
      unique case (state_r)
        C_LOAD: begin
          rem_r   <= '0;
          quo_r   <= sw_r;
          step_r  <= '0;
          state_r <= C_DIV_W;
        end
        C_DIV_W: begin
          if (last_step) begin
            bx_r      <= quo_nxt;
            rw_zero_r <= rem_nxt == '0;
            rem_r     <= '0;
            quo_r     <= sh_r;
            step_r    <= '0;
            state_r   <= C_DIV_H;
          end else begin
            step_r <= step_r + 1'b1;
            rem_r  <= rem_nxt;
            quo_r  <= quo_nxt;
          end
        end
        C_DIV_H: begin
          if (last_step) begin
            by_r      <= quo_nxt;
            rh_zero_r <= rem_nxt == '0;
            state_r   <= C_MUL;
          end else begin
            step_r <= step_r + 1'b1;
            rem_r  <= rem_nxt;
            quo_r  <= quo_nxt;
          end
        end
        C_MUL: begin
          bsize_r <= prod[BS_W-1:0];
          ok_r    <= ok_nxt;
          busy_r  <= 1'b0;
          state_r <= C_DONE;
        end
        C_DONE: state_r <= C_DONE;
        default: state_r <= C_LOAD;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SRC_WIDTH:  prdata[CFG_W-1:0] = sw_r;
      REG_SRC_HEIGHT: prdata[CFG_W-1:0] = sh_r;
      REG_DST_WIDTH:  prdata[CFG_W-1:0] = dw_r;
      REG_DST_HEIGHT: prdata[CFG_W-1:0] = dh_r;
    endcase
  end

  assign stat.busy       = busy_r;
  assign stat.ok         = ok_r;
  assign stat.src_width  = sw_r;
  assign stat.src_height = sh_r;
  assign stat.bx         = bx_r;
  assign stat.by         = by_r;
  assign stat.bsize      = bsize_r;

endmodule

[hdl/bgad_dp.sv]
// Datapath: raster counters, column-sum memory and the rounding divider.
module bgad_dp #(
  parameter int MAX_DST_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bgad_pkg::dp_cmd_t           cmd,
  input  bgad_pkg::cfg_stat_t         cfg,
  input  logic [bgad_pkg::PIX_W-1:0]  pixel,
  input  logic                        frame_start,
  output bgad_pkg::dp_stat_t          st,
  output logic [bgad_pkg::PIX_W-1:0]  avg_pixel,
  output logic                        frame_end
);
  import bgad_pkg::*;

  localparam int AW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
  localparam logic [12:0] MAX_DW = 13'(MAX_DST_WIDTH);

  // Frame position and block state.
  logic [CFG_W-1:0] sc_r, sr_r, bco_r, bro_r, oc_r;
  logic [BS_W-1:0]  bs_r;
  logic             fi_r;

  // Item latched at acceptance.
  logic [PIX_W-1:0] pix_r;
  logic             active_r, first_r, last_r, fend_r;
  logic [AW-1:0]    addr_r;
  logic [SUM_W-1:0] rdata_r;

  // Divider.
  logic [NUM_W-1:0] num_r, dsh_r;
  logic [QUO_W-1:0] quo_r;

  // Output register.
  logic [PIX_W-1:0] obuf_pix_r;
  logic             obuf_fend_r;

  logic [SUM_W-1:0] mem [MAX_DST_WIDTH];

  logic [CFG_W-1:0] sc_e, sr_e, bco_e, bro_e, oc_e;
  logic             fi_e, run, active, first, last, fend;
  logic [BS_W-1:0]  bs_e;
  logic [AW-1:0]    addr_e;
  logic [CFG_W:0]   sc1, sr1, bco1, bro1, oc1;
  logic [CFG_W-1:0] sc_n, sr_n, bco_n, bro_n, oc_n;
  logic             fi_n;
  logic [SUM_W-1:0] sum_nxt;
  logic             ge;
  logic [PIX_W-1:0] avg_sat;

  always_comb begin
    sc_e  = frame_start ? '0 : sc_r;
    sr_e  = frame_start ? '0 : sr_r;
    bco_e = frame_start ? '0 : bco_r;
    bro_e = frame_start ? '0 : bro_r;
    oc_e  = frame_start ? '0 : oc_r;
    fi_e  = frame_start ? !cfg.ok : fi_r;
    bs_e  = frame_start ? (cfg.ok ? cfg.bsize : '0) : bs_r;
    run    = !fi_e && cfg.ok && (bs_e != '0);
    active = run && ({2'b0, oc_e} < MAX_DW);
    addr_e = AW'(oc_e);

    sc1  = {1'b0, sc_e} + 1'b1;
    sr1  = {1'b0, sr_e} + 1'b1;
    bco1 = {1'b0, bco_e} + 1'b1;
    bro1 = {1'b0, bro_e} + 1'b1;
    oc1  = {1'b0, oc_e} + 1'b1;

    first = (bco_e == '0) && (bro_e == '0);
    last  = (bco1 >= {1'b0, cfg.bx}) && (bro1 >= {1'b0, cfg.by});
    fend  = (sc1 >= {1'b0, cfg.src_width}) && (sr1 >= {1'b0, cfg.src_height});

    // Advance across the row, then wrap to the next row and frame.
    sc_n  = sc1[CFG_W-1:0];
    sr_n  = sr_e;
    bco_n = bco1[CFG_W-1:0];
    bro_n = bro_e;
    oc_n  = oc_e;
    fi_n  = fi_e;
    if (bco1 >= {1'b0, cfg.bx}) begin
      bco_n = '0;
      oc_n  = oc1[CFG_W-1:0];
    end
    if (sc1 >= {1'b0, cfg.src_width}) begin
      sc_n  = '0;
      bco_n = '0;
      oc_n  = '0;
      sr_n  = sr1[CFG_W-1:0];
      bro_n = (bro1 >= {1'b0, cfg.by}) ? '0 : bro1[CFG_W-1:0];
      if (sr1 >= {1'b0, cfg.src_height}) begin
        sr_n = '0;
        fi_n = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r  <= '0;
      sr_r  <= '0;
      bco_r <= '0;
      bro_r <= '0;
      oc_r  <= '0;
      bs_r  <= '0;
      fi_r  <= 1'b1;
      active_r <= 1'b0;
      last_r   <= 1'b0;
    end else if (cmd.accept) begin
      bs_r     <= bs_e;
      active_r <= active;
      last_r   <= last;
      if (run) begin
        sc_r  <= sc_n;
        sr_r  <= sr_n;
        bco_r <= bco_n;
        bro_r <= bro_n;
        oc_r  <= oc_n;
        fi_r  <= fi_n;
      end else begin
        sc_r  <= sc_e;
        sr_r  <= sr_e;
        bco_r <= bco_e;
        bro_r <= bro_e;
        oc_r  <= oc_e;
        fi_r  <= fi_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r   <= pixel;
      first_r <= first;
      fend_r  <= fend;
      addr_r  <= addr_e;
    end
  end

  // Column sums: read when the item is taken, written back in the following cycle.
  assign sum_nxt = first_r ? SUM_W'(pix_r) : rdata_r + SUM_W'(pix_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata_r <= mem[addr_e];
    end
    if (cmd.acc && active_r) begin
      mem[addr_r] <= sum_nxt;
    end
  end

  // Restoring division of (sum + size/2) by size, one quotient bit a cycle;
  // a set top bit means the average exceeds the pixel range.
  assign ge = num_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      num_r <= NUM_W'(sum_nxt) + NUM_W'(bs_r >> 1);
      dsh_r <= {bs_r, {PIX_W{1'b0}}};
      quo_r <= '0;
    end else if (cmd.div) begin
      num_r <= ge ? num_r - dsh_r : num_r;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign avg_sat = quo_r[QUO_W-1] ? {PIX_W{1'b1}} : quo_r[PIX_W-1:0];

  // The finished average waits here, so the next pixel can be taken meanwhile.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obuf_pix_r  <= avg_sat;
      obuf_fend_r <= fend_r;
    end
  end

  assign st.emit   = active_r && last_r;
  assign avg_pixel = obuf_pix_r;
  assign frame_end = obuf_fend_r;

endmodule

[hdl/bgad_ctrl.sv]
// Controller that sequences acceptance, accumulation, division and output.
module bgad_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_busy,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bgad_pkg::dp_stat_t  st,
  output bgad_pkg::dp_cmd_t   cmd
);
  import bgad_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_DIV, S_OUT} state_t;

  state_t            state_r;
  logic [STEP_W-1:0] cnt_r;
  logic              out_vld_r;
  logic              obuf_free;

  // The output register can take a new average when it is empty or being read.
  assign obuf_free  = !out_vld_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && !cfg_busy;
  assign out_valid  = out_vld_r;
  assign cmd.accept = in_ready && in_valid;
  assign cmd.acc    = state_r == S_ACC;
  assign cmd.div    = state_r == S_DIV;
  assign cmd.load   = (state_r == S_OUT) && obuf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          cnt_r   <= '0;
          state_r <= st.emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (obuf_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/gray_block_average_downscale_core.sv]
// Top level of the gray block-average downscaler.
//
//   port group   direction  what it moves
//   in_ch        sink       one source pixel per item, frame_start on the first
//   out_ch       source     one block average per item, frame_end on the last
//   psel..prdata APB slave  src_width, src_height, dst_width, dst_height
//
// An item that completes no block passes acceptance and accumulation; an item
// that completes a block also passes the one-bit-per-cycle divider that forms
// the rounded average (9 quotient bits) and the move into the output register.
// After reset and after every register write the block holds in_ch.ready low
// while a shared 11-bit serial divider derives the block width, block height
// and validity of the geometry; block size then follows from one multiply.
// Reset is synchronous and active low. A stalled output closes the input only
// once a second average is ready while the first still waits.
module gray_block_average_downscale_core #(
  parameter int MAX_DST_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bgad_in_if.sink                        in_ch,
  bgad_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bgad_pkg::APB_AW-1:0]    paddr,
  input  logic [bgad_pkg::APB_DW-1:0]    pwdata,
  output logic [bgad_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import bgad_pkg::*;

  cfg_stat_t cfg_stat;
  dp_cmd_t   cmd;
  dp_stat_t  st;

  // Registers never wait.
  assign pready = 1'b1;

  // Register file plus the geometry unit.
  bgad_cfg #(
    .MAX_DST_WIDTH(MAX_DST_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .stat    (cfg_stat)
  );

  // The controller owns both handshakes; the datapath only follows commands.
  bgad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_busy  (cfg_stat.busy),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Counters, column-sum memory, the averaging divider and the output register.
  bgad_dp #(
    .MAX_DST_WIDTH(MAX_DST_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_stat),
    .pixel       (in_ch.pixel),
    .frame_start (in_ch.frame_start),
    .st          (st),
    .avg_pixel   (out_ch.avg_pixel),
    .frame_end   (out_ch.frame_end)
  );

endmodule

[dv/gray_block_average_downscale_core_tb.sv]
// Self-checking testbench of the gray block-average downscaler: directed plan, random frames.
module gray_block_average_downscale_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgad_pkg::*;

  // The core is built with its default column capacity, so the same bound applies here.
  localparam int DST_LIMIT = 1024;

  // Generous bound on the whole run, in clock cycles. It covers a slow but correct run of
  // about 800 items, plus register writes with their geometry recalculation and one long
  // output stall.
  localparam int CYCLE_LIMIT = 600000;

  // Number of pixels that the random part must get into live frames.
  localparam int RANDOM_ITEMS = 750;

  // Cycles of quiet before a register write. An item that completes no block is still in
  // its accumulation step after it is taken, so the pause covers that with margin.
  localparam int WRITE_PAUSE = 16;

  // Cycles to wait after the last expected average before the verdict.
  localparam int DRAIN_CYCLES = 40;

  // Output stall that forces the core to fill up and close its input.
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 60;

  typedef struct packed {
    logic [PIX_W-1:0] avg_pixel;
    logic             frame_end;
  } avg_item_t;

  // A plan row either writes one register or sends one pixel. A pixel row says how its
  // outcome is judged: by the predictor, by a result typed into the row, or as silent.
  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_REG
  } row_kind_t;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_TYPED,
    CHK_SILENT
  } check_kind_t;

  typedef struct {
    row_kind_t        kind;
    reg_idx_t         ridx;
    logic [CFG_W-1:0] value;
    logic [PIX_W-1:0] pix;
    logic             fs;
    check_kind_t      chk;
    avg_item_t        typed;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bgad_in_if  in_if ();
  bgad_out_if out_if ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  gray_block_average_downscale_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor state: the geometry registers as the core holds them, and the raster position
  // of the current frame together with one running block sum per output column.
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0]  geo_regs [4];
  longint unsigned   col_sum [DST_LIMIT];
  int unsigned       ras_col, ras_row, blk_col, blk_row, avg_col;
  longint unsigned   blk_pixels;
  bit                frame_dead;

  // Averages still owed by the core, oldest first.
  avg_item_t pending_avgs [$];

  int unsigned fail_count  = 0;
  int unsigned live_items  = 0;
  int unsigned taken_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_calm    = 0;
  int unsigned dst_calm    = 0;

  // The geometry is usable only when all four sizes are nonzero, the target sizes divide
  // the source sizes, and each source size and the target width stay within their maxima.
  function automatic bit geometry_ok();
    int unsigned sw, sh, dw, dh;
    sw = geo_regs[REG_SRC_WIDTH];
    sh = geo_regs[REG_SRC_HEIGHT];
    dw = geo_regs[REG_DST_WIDTH];
    dh = geo_regs[REG_DST_HEIGHT];
    if (sw == 0 || sw > MAX_SRC_WIDTH) return 1'b0;
    if (sh == 0 || sh > MAX_SRC_HEIGHT) return 1'b0;
    if (dw == 0 || dw > DST_LIMIT) return 1'b0;
    if (dh == 0) return 1'b0;
    if (sw % dw != 0) return 1'b0;
    if (sh % dh != 0) return 1'b0;
    return 1'b1;
  endfunction

  // Advances the raster by one accepted pixel. Reports whether the pixel closed a block (and
  // the rounded average it yields) and whether the pixel belonged to a live frame at all.
  function automatic void downscale_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                                          output bit made, output avg_item_t res,
                                          output bit used);
    bit              ok;
    int unsigned     sw, sh, bx, by;
    longint unsigned avg;
    ok   = geometry_ok();
    made = 1'b0;
    used = 1'b0;
    res  = '0;
    sw   = geo_regs[REG_SRC_WIDTH];
    sh   = geo_regs[REG_SRC_HEIGHT];

    // A frame start rewinds the raster and latches the block size of the new frame.
    if (fs) begin
      ras_col    = 0;
      ras_row    = 0;
      blk_col    = 0;
      blk_row    = 0;
      avg_col    = 0;
      frame_dead = !ok;
      blk_pixels = ok ? longint'(sw / geo_regs[REG_DST_WIDTH]) *
                        longint'(sh / geo_regs[REG_DST_HEIGHT]) : 0;
    end
    if (frame_dead || !ok || blk_pixels == 0) return;

    used = 1'b1;
    bx   = sw / geo_regs[REG_DST_WIDTH];
    by   = sh / geo_regs[REG_DST_HEIGHT];

    if (avg_col < DST_LIMIT) begin
      // The top-left pixel of a block opens its column sum; the others add to it.
      if (blk_col == 0 && blk_row == 0) begin
        col_sum[avg_col] = pix;
      end else begin
        col_sum[avg_col] += pix;
      end
      // The bottom-right pixel closes the block: round to nearest and clamp.
      if (blk_col + 1 >= bx && blk_row + 1 >= by) begin
        avg = (col_sum[avg_col] + blk_pixels / 2) / blk_pixels;
        if (avg > 255) avg = 255;
        res.avg_pixel = avg[PIX_W-1:0];
        res.frame_end = (ras_col + 1 >= sw && ras_row + 1 >= sh);
        made = 1'b1;
      end
    end

    ras_col++;
    blk_col++;
    if (blk_col >= bx) begin
      blk_col = 0;
      avg_col++;
    end
    if (ras_col >= sw) begin
      ras_col = 0;
      blk_col = 0;
      avg_col = 0;
      ras_row++;
      blk_row++;
      if (blk_row >= by) blk_row = 0;
      // After the last pixel the frame is over; further pixels wait for a frame start.
      if (ras_row >= sh) begin
        ras_row    = 0;
        frame_dead = 1'b1;
      end
    end
  endfunction

  // Wait before the next item: mostly a random draw, but now and then a run of back-to-back
  // items so that the core also sees full rate.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic plan_row_t px(input logic [PIX_W-1:0] pix, input logic fs,
                                   input check_kind_t chk, input logic [PIX_W-1:0] avg,
                                   input logic fe);
    plan_row_t r;
    r       = '{kind: ROW_PIXEL, ridx: REG_SRC_WIDTH, value: '0, pix: pix, fs: fs,
                chk: chk, typed: '0};
    r.typed = '{avg_pixel: avg, frame_end: fe};
    return r;
  endfunction

  function automatic plan_row_t wr(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    plan_row_t r;
    r = '{kind: ROW_REG, ridx: idx, value: v, pix: '0, fs: 1'b0, chk: CHK_SILENT,
          typed: '0};
    return r;
  endfunction

  // Offers one pixel after a random gap, holds it until the core takes it, and then books
  // the average it should produce. valid stays high when the next pixel follows at once.
  task automatic drive_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                             input check_kind_t chk, input avg_item_t typed);
    int unsigned gap;
    bit          made, used;
    avg_item_t   res;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel       <= pix;
    in_if.frame_start <= fs;
    do @(posedge clk); while (!in_if.ready);
    downscale_pixel(pix, fs, made, res, used);
    if (used) live_items++;
    case (chk)
      CHK_PREDICT: begin
        if (made) pending_avgs.push_back(res);
      end
      CHK_TYPED: begin
        pending_avgs.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  // Register writes happen only with the core idle: the input is closed, every owed average
  // has come back, and a short pause lets any pixel still inside the core settle.
  task automatic write_geometry_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    in_if.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (WRITE_PAUSE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    geo_regs[idx] = v;
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checker: every average taken from the core must match the oldest one owed.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : check_averages
    avg_item_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_avgs.size() == 0) begin
        $display("%0t: unexpected average: expected none, got avg_pixel %0d frame_end %0b",
                 $time, out_if.avg_pixel, out_if.frame_end);
        fail_count++;
      end else begin
        want = pending_avgs.pop_front();
        if (out_if.avg_pixel !== want.avg_pixel) begin
          $display("%0t: avg_pixel mismatch: expected %0d, got %0d",
                   $time, want.avg_pixel, out_if.avg_pixel);
          fail_count++;
        end
        if (out_if.frame_end !== want.frame_end) begin
          $display("%0t: frame_end mismatch: expected %0b, got %0b",
                   $time, want.frame_end, out_if.frame_end);
          fail_count++;
        end
      end
    end
  end

  // Run limit: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output side: ready drops for a random number of cycles before each average. Once, after
  // some averages have gone through, it stays low for a long stretch while the input side
  // keeps offering pixels, so the core backs up and closes its input.
  // ---------------------------------------------------------------------------------------
  initial begin : drain_averages
    int unsigned gap;
    bit          held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(dst_calm);
      if (!held && taken_count >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        gap  = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      taken_count++;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus: reset, the directed plan, then random phases of geometry and frames.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t   plan [$];
    int unsigned scen, sw, sh, dw, dh, bx, by, frames, frame_len, n, trail, mode, sel;
    logic [PIX_W-1:0] pix;

    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.pixel       <= '0;
    in_if.frame_start <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    geo_regs[REG_SRC_WIDTH]  = RST_SRC_WIDTH;
    geo_regs[REG_SRC_HEIGHT] = RST_SRC_HEIGHT;
    geo_regs[REG_DST_WIDTH]  = RST_DST_WIDTH;
    geo_regs[REG_DST_HEIGHT] = RST_DST_HEIGHT;
    foreach (col_sum[i]) col_sum[i] = 0;
    ras_col    = 0;
    ras_row    = 0;
    blk_col    = 0;
    blk_row    = 0;
    avg_col    = 0;
    blk_pixels = 0;
    frame_dead = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Pixels before any frame start are dropped. Under the reset geometry (10 by 10 blocks)
    // a few pixels of a new frame cannot close a block.
    plan.push_back(px(8'h5A, 1'b0, CHK_SILENT, 8'd0, 1'b0));
    plan.push_back(px(8'hFF, 1'b1, CHK_SILENT, 8'd0, 1'b0));
    plan.push_back(px(8'h00, 1'b0, CHK_SILENT, 8'd0, 1'b0));

    // One-pixel frames: the average is the pixel itself and it always ends the frame. A
    // pixel after the end of the frame is dropped.
    plan.push_back(wr(REG_SRC_WIDTH, 11'd1));
    plan.push_back(wr(REG_SRC_HEIGHT, 11'd1));
    plan.push_back(wr(REG_DST_WIDTH, 11'd1));
    plan.push_back(wr(REG_DST_HEIGHT, 11'd1));
    plan.push_back(px(8'h00, 1'b1, CHK_TYPED, 8'd0, 1'b1));
    plan.push_back(px(8'hFF, 1'b1, CHK_TYPED, 8'd255, 1'b1));
    plan.push_back(px(8'h33, 1'b0, CHK_SILENT, 8'd0, 1'b0));

    // A 2 by 2 frame shrunk to one pixel; the sum sits exactly halfway and rounds up.
    plan.push_back(wr(REG_SRC_WIDTH, 11'd2));
    plan.push_back(wr(REG_SRC_HEIGHT, 11'd2));
    plan.push_back(px(8'd1, 1'b1, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd2, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd2, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd1, 1'b0, CHK_PREDICT, 8'd0, 1'b0));

    // Zero target width, then a target width that does not divide the source: no output.
    plan.push_back(wr(REG_DST_WIDTH, 11'd0));
    plan.push_back(px(8'h80, 1'b1, CHK_SILENT, 8'd0, 1'b0));
    plan.push_back(wr(REG_DST_WIDTH, 11'd3));
    plan.push_back(px(8'h7F, 1'b1, CHK_SILENT, 8'd0, 1'b0));

    // Largest geometry with one-pixel blocks: every pixel is its own average.
    plan.push_back(wr(REG_SRC_WIDTH, 11'd1024));
    plan.push_back(wr(REG_SRC_HEIGHT, 11'd1024));
    plan.push_back(wr(REG_DST_WIDTH, 11'd1024));
    plan.push_back(wr(REG_DST_HEIGHT, 11'd1024));
    plan.push_back(px(8'hFF, 1'b1, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'h00, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'hAA, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'h55, 1'b0, CHK_PREDICT, 8'd0, 1'b0));

    // The whole frame as one block: far too large to complete here, so nothing comes out.
    plan.push_back(wr(REG_DST_WIDTH, 11'd1));
    plan.push_back(wr(REG_DST_HEIGHT, 11'd1));
    plan.push_back(px(8'hFF, 1'b1, CHK_SILENT, 8'd0, 1'b0));

    // A frame restarted after two pixels, then run to its end; a stray pixel follows.
    plan.push_back(wr(REG_SRC_WIDTH, 11'd3));
    plan.push_back(wr(REG_SRC_HEIGHT, 11'd2));
    plan.push_back(wr(REG_DST_WIDTH, 11'd3));
    plan.push_back(px(8'd10, 1'b1, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd20, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd30, 1'b1, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd40, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd50, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd60, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd70, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'd80, 1'b0, CHK_PREDICT, 8'd0, 1'b0));
    plan.push_back(px(8'h99, 1'b0, CHK_SILENT, 8'd0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_geometry_reg(plan[i].ridx, plan[i].value);
      end else begin
        drive_pixel(plan[i].pix, plan[i].fs, plan[i].chk, plan[i].typed);
      end
    end

    // Random phases. Each phase sets a fresh geometry and starts with a frame start, so no
    // column sum is ever read before the frame has opened it. Most phases are small valid
    // geometries with whole frames; the rest are invalid geometries and the largest sizes,
    // plus frames cut short or followed by stray pixels.
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      scen   = $urandom_range(0, 9);
      frames = 1;
      if (scen == 0) begin
        // Invalid: either a target width wider than the source, or a zero target height.
        sw = $urandom_range(1, 40);
        sh = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 1) begin
          dw = sw + 1;
          dh = 1;
        end else begin
          dw = 1;
          dh = 0;
        end
        frame_len = $urandom_range(3, 12);
      end else if (scen == 1) begin
        // Full-width lines; the frame is far too long to finish, so it is cut short.
        sw  = 1024;
        sh  = ($urandom_range(0, 1) == 1) ? 1024 : 1;
        dh  = sh;
        sel = $urandom_range(0, 2);
        dw  = (sel == 0) ? 1024 : (sel == 1) ? 512 : 1;
        frame_len = $urandom_range(20, 60);
      end else begin
        dw = $urandom_range(1, 6);
        bx = $urandom_range(1, 4);
        dh = $urandom_range(1, 3);
        by = $urandom_range(1, 3);
        sw = dw * bx;
        sh = dh * by;
        frame_len = sw * sh;
        frames    = $urandom_range(1, 3);
      end

      write_geometry_reg(REG_SRC_WIDTH, CFG_W'(sw));
      write_geometry_reg(REG_SRC_HEIGHT, CFG_W'(sh));
      write_geometry_reg(REG_DST_WIDTH, CFG_W'(dw));
      write_geometry_reg(REG_DST_HEIGHT, CFG_W'(dh));

      for (int f = 0; f < frames; f++) begin
        n     = frame_len;
        trail = 0;
        mode  = $urandom_range(0, 7);
        if (mode == 0) n = $urandom_range(1, frame_len);
        if (mode == 1) trail = $urandom_range(1, 5);
        for (int k = 0; k < n + trail; k++) begin
          sel = $urandom_range(0, 15);
          pix = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : PIX_W'($urandom_range(0, 255));
          drive_pixel(pix, k == 0, CHK_PREDICT, '0);
        end
      end
    end

    // Drain: close the input, wait for every owed average, then watch a while for extras.
    in_if.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bgad_pkg.sv
hdl/bgad_if.sv
hdl/bgad_cfg.sv
hdl/bgad_dp.sv
hdl/bgad_ctrl.sv
hdl/gray_block_average_downscale_core.sv
dv/gray_block_average_downscale_core_tb.sv
